// ===== rtl/hs_pkg.sv =====
// ----------------------------------------------------------------------------
// hs_pkg
// shared sizes and types of the heap sorter
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int CAPACITY = 64;                      // words held per set
    localparam int DATA_W   = 32;                      // element width
    localparam int ADDR_W   = $clog2(CAPACITY);        // store address width
    localparam int CNT_W    = $clog2(CAPACITY + 1);    // fill count width
    localparam int CHILD_W  = CNT_W + 1;               // width of 2*i+2

    // one sorted word handed from the engine to the output register
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } emit_t;

endpackage

// ===== rtl/heap_sorter.sv =====
// ----------------------------------------------------------------------------
// heap_sorter
// collects a set of signed words and returns them in ascending order
// ----------------------------------------------------------------------------
//
// channel   dir   tdata            tlast          tuser
// s_        in    element[31:0]    final_element  -
// m_        out   sorted_value     run_end        overflowed
//
// loading takes one word per cycle; the store accepts up to CAPACITY words,
// later words of the set are dropped and flag the run as overflowed
// sorting is an in-place heapsort in one single-port-read ram: a sift-down
// level reads the left child, then the right, then compares and writes; a
// build step adds check, read and capture states and an extraction step
// adds check, root and end reads and swap; readout reads, then emits a word
// s_tready is low from the final word until the last sorted word has been
// loaded into the output register; m_ stalls simply hold the sequencer
// reset clears the fill count, overflow flag, sequencer and output valid
//
module heap_sorter (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element
    input  logic        s_tlast,   // final_element

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // run_end
    output logic        m_tuser    // [0] overflowed
);

    hs_pkg::emit_t                emit;
    logic                         out_free;

    // output register parts the sequencer from the result side
    logic                         m_tvalid_reg;
    logic [hs_pkg::DATA_W-1:0]    m_tdata_reg;
    logic                         m_tlast_reg;
    logic                         m_tuser_reg;

    // register can take a word next cycle if it is empty or draining now
    assign out_free = !m_tvalid_reg || m_tready;

    hs_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .out_free (out_free),
        .emit     (emit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // payload loads only when a sorted word is handed over
    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            m_tdata_reg <= emit.value;
            m_tlast_reg <= emit.last;
            m_tuser_reg <= emit.ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/hs_ram.sv =====
// ----------------------------------------------------------------------------
// hs_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/hs_engine.sv =====
// ----------------------------------------------------------------------------
// hs_engine
// load, in-place heapsort and readout sequencer around the element store
// ----------------------------------------------------------------------------
module hs_engine (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [hs_pkg::DATA_W-1:0] in_data,
    input  logic                      in_last,
    input  logic                      out_free,
    output hs_pkg::emit_t             emit
);

    localparam logic [3:0] ST_LOAD      = 4'd0;
    localparam logic [3:0] ST_BLD_CHK   = 4'd1;
    localparam logic [3:0] ST_BLD_RD    = 4'd2;
    localparam logic [3:0] ST_BLD_CAP   = 4'd3;
    localparam logic [3:0] ST_SFT_L     = 4'd4;
    localparam logic [3:0] ST_SFT_R     = 4'd5;
    localparam logic [3:0] ST_SFT_CMP   = 4'd6;
    localparam logic [3:0] ST_EXT_START = 4'd7;
    localparam logic [3:0] ST_EXT_CHK   = 4'd8;
    localparam logic [3:0] ST_EXT_RD0   = 4'd9;
    localparam logic [3:0] ST_EXT_RDI   = 4'd10;
    localparam logic [3:0] ST_EXT_SWP   = 4'd11;
    localparam logic [3:0] ST_EMIT_RD   = 4'd12;
    localparam logic [3:0] ST_EMIT_WT   = 4'd13;

    localparam logic PH_BUILD   = 1'b0;
    localparam logic PH_EXTRACT = 1'b1;

    logic [3:0]                      state_reg, state_next;
    logic                            phase_reg, phase_next;
    logic [hs_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                            ovf_reg, ovf_next;
    logic [hs_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic [hs_pkg::CNT_W-1:0]        size_reg, size_next;
    logic [hs_pkg::ADDR_W-1:0]       cur_reg, cur_next;
    logic signed [hs_pkg::DATA_W-1:0] curval_reg, curval_next;
    logic signed [hs_pkg::DATA_W-1:0] lval_reg, lval_next;

    logic                        ram_we;
    logic [hs_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [hs_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;

    logic [hs_pkg::CHILD_W-1:0]  left_idx, right_idx;
    logic                        left_ok, right_ok;
    logic signed [hs_pkg::DATA_W-1:0] rval, bigval;
    logic                        l_win, r_win, room;
    logic [hs_pkg::CNT_W-1:0]    cnt_inc;

    hs_ram #(
        .WIDTH (hs_pkg::DATA_W),
        .DEPTH (hs_pkg::CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // children of the current hole
    assign left_idx  = {cur_reg, 1'b0} + hs_pkg::CHILD_W'(1);
    assign right_idx = {cur_reg, 1'b0} + hs_pkg::CHILD_W'(2);
    assign left_ok   = left_idx  < {1'b0, size_reg};
    assign right_ok  = right_idx < {1'b0, size_reg};

    // child compare, ties keep the parent and then the left child
    assign rval   = $signed(ram_rdata);
    assign l_win  = lval_reg > curval_reg;
    assign bigval = l_win ? lval_reg : curval_reg;
    assign r_win  = right_ok && (rval > bigval);

    assign room    = count_reg < hs_pkg::CNT_W'(hs_pkg::CAPACITY);
    assign cnt_inc = room ? count_reg + hs_pkg::CNT_W'(1) : count_reg;

    assign in_ready = (state_reg == ST_LOAD);

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        size_next   = size_reg;
        cur_next    = cur_reg;
        curval_next = curval_reg;
        lval_next   = lval_reg;
        ram_we      = 1'b0;
        ram_waddr   = cur_reg;
        ram_wdata   = curval_reg;
        ram_raddr   = cur_reg;
        emit        = '0;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_valid) begin
                    if (room) begin
                        ram_we    = 1'b1;
                        ram_waddr = count_reg[hs_pkg::ADDR_W-1:0];
                        ram_wdata = in_data;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    count_next = cnt_inc;
                    if (in_last) begin
                        idx_next   = cnt_inc >> 1;
                        phase_next = PH_BUILD;
                        state_next = ST_BLD_CHK;
                    end
                end
            end
            ST_BLD_CHK: begin
                state_next = (idx_reg != '0) ? ST_BLD_RD : ST_EXT_START;
            end
            ST_BLD_RD: begin
                ram_raddr  = hs_pkg::ADDR_W'(idx_reg - hs_pkg::CNT_W'(1));
                cur_next   = hs_pkg::ADDR_W'(idx_reg - hs_pkg::CNT_W'(1));
                size_next  = count_reg;
                state_next = ST_BLD_CAP;
            end
            ST_BLD_CAP: begin
                curval_next = $signed(ram_rdata);
                state_next  = ST_SFT_L;
            end
            ST_SFT_L: begin
                if (left_ok) begin
                    ram_raddr  = left_idx[hs_pkg::ADDR_W-1:0];
                    state_next = ST_SFT_R;
                end else begin
                    // leaf: drop the held value into the hole
                    ram_we     = 1'b1;
                    idx_next   = idx_reg - hs_pkg::CNT_W'(1);
                    state_next = (phase_reg == PH_BUILD) ? ST_BLD_CHK : ST_EXT_CHK;
                end
            end
            ST_SFT_R: begin
                lval_next  = $signed(ram_rdata);
                ram_raddr  = right_idx[hs_pkg::ADDR_W-1:0];
                state_next = ST_SFT_CMP;
            end
            ST_SFT_CMP: begin
                ram_we = 1'b1;
                if (!l_win && !r_win) begin
                    idx_next   = idx_reg - hs_pkg::CNT_W'(1);
                    state_next = (phase_reg == PH_BUILD) ? ST_BLD_CHK : ST_EXT_CHK;
                end else begin
                    // larger child moves up, hole moves down
                    ram_wdata  = r_win ? rval : lval_reg;
                    cur_next   = r_win ? right_idx[hs_pkg::ADDR_W-1:0]
                                       : left_idx[hs_pkg::ADDR_W-1:0];
                    state_next = ST_SFT_L;
                end
            end
            ST_EXT_START: begin
                phase_next = PH_EXTRACT;
                idx_next   = count_reg - hs_pkg::CNT_W'(1);
                state_next = ST_EXT_CHK;
            end
            ST_EXT_CHK: begin
                state_next = (idx_reg != '0) ? ST_EXT_RD0 : ST_EMIT_RD;
            end
            ST_EXT_RD0: begin
                ram_raddr  = '0;
                state_next = ST_EXT_RDI;
            end
            ST_EXT_RDI: begin
                lval_next  = $signed(ram_rdata);
                ram_raddr  = idx_reg[hs_pkg::ADDR_W-1:0];
                state_next = ST_EXT_SWP;
            end
            ST_EXT_SWP: begin
                // root goes to the end, old end word sifts down from the root
                curval_next = $signed(ram_rdata);
                ram_we      = 1'b1;
                ram_waddr   = idx_reg[hs_pkg::ADDR_W-1:0];
                ram_wdata   = lval_reg;
                cur_next    = '0;
                size_next   = idx_reg;
                state_next  = ST_SFT_L;
            end
            ST_EMIT_RD: begin
                ram_raddr = idx_reg[hs_pkg::ADDR_W-1:0];
                if (out_free) begin
                    state_next = ST_EMIT_WT;
                end
            end
            ST_EMIT_WT: begin
                emit.valid = 1'b1;
                emit.value = $signed(ram_rdata);
                emit.last  = (idx_reg == count_reg - hs_pkg::CNT_W'(1));
                emit.ovf   = ovf_reg;
                if (emit.last) begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end else begin
                    idx_next   = idx_reg + hs_pkg::CNT_W'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            phase_reg <= PH_BUILD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg   <= size_next;
        cur_reg    <= cur_next;
        curval_reg <= curval_next;
        lval_reg   <= lval_next;
    end

endmodule
